/* design/wav_pcm_stream_parser_core_defines.svh */
// assertion helpers shared by the parser block
`ifndef WAV_PCM_STREAM_PARSER_CORE_DEFINES_SVH
`define WAV_PCM_STREAM_PARSER_CORE_DEFINES_SVH

// same-cycle implication, checked only out of reset
`define WPSP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked only out of reset
`define WPSP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/wpsp_pkg.sv */
package wpsp_pkg;

  // chunk tags, little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // accepted fmt chunk sizes
  localparam logic [31:0] FMT_SIZE_BASE = 32'd16;
  localparam logic [31:0] FMT_SIZE_EXT  = 32'd18;
  localparam logic [31:0] FMT_SIZE_EXTENSIBLE = 32'd40;

  localparam logic [31:0] FORMAT_PCM      = 32'd1;
  localparam logic [31:0] BITS_8          = 32'd8;
  localparam logic [31:0] BITS_16         = 32'd16;
  // byte rate and block align bytes between rate and bits fields
  localparam logic [31:0] SKIP_ALIGN_BYTES = 32'd6;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    ERR_RIFF     = 3'd0,
    ERR_WAVE     = 3'd1,
    ERR_FMT_SIZE = 3'd2,
    ERR_NOT_PCM  = 3'd3,
    ERR_CHANNELS = 3'd4,
    ERR_RATE     = 3'd5,
    ERR_BITS     = 3'd6
  } err_code_e;

  typedef struct packed {
    result_kind_e       kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [1:0]         channel_count;
    logic [31:0]        sample_rate;
    logic [4:0]         sample_bits;
    err_code_e          error_code;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } res_push_t;

endpackage

/* design/wpsp_ifs.sv */
interface wpsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

interface wpsp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [1:0]         channel_count;
  logic [31:0]        sample_rate;
  logic [4:0]         sample_bits;
  logic [2:0]         error_code;

  modport source (
    output valid, output result_kind, output left_sample, output right_sample,
    output channel_count, output sample_rate, output sample_bits, output error_code,
    input ready
  );
  modport sink (
    input valid, input result_kind, input left_sample, input right_sample,
    input channel_count, input sample_rate, input sample_bits, input error_code,
    output ready
  );
endinterface

/* design/wav_pcm_stream_parser_core.sv */
// a word that completes a result is registered into the queue whose head drives out_o
// throughput: one byte word per cycle while the queue has room, parsed in the front
// in_i.ready drops only while the QueueDepth-entry result queue is full
// reset (async, active low) returns the parser to waiting for the RIFF tag and empties
// the queue; file_start on a word restarts parsing from that word itself
module wav_pcm_stream_parser_core #(
  // result words buffered between parser and output
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wpsp_in_if.sink    in_i,
  wpsp_out_if.source out_o
);

  // push from the parser front into the result queue
  wpsp_pkg::res_push_t push;
  logic                queue_full;

  // front: header state machine and frame packing, one byte each cycle
  // while the queue has room; raises at most one result word per byte
  wpsp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  // back: short result queue whose head drives the output channel, so a
  // stalled sink does not stop byte intake until the queue fills
  wpsp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .out_o  (out_o)
  );

endmodule

/* design/wpsp_front.sv */
module wpsp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  wpsp_in_if.sink             in_i,
  input  logic                queue_full_i,
  output wpsp_pkg::res_push_t push_o
);

  typedef enum logic [3:0] {
    PH_RIFF, PH_RIFF_SIZE, PH_WAVE, PH_SCAN_FMT, PH_FMT_SIZE, PH_FORMAT,
    PH_CHANNELS, PH_RATE, PH_SKIP6, PH_BITS, PH_EXTRA, PH_CHUNK_ID,
    PH_CHUNK_SIZE, PH_SKIP_BODY, PH_DATA_SIZE, PH_STREAM
  } phase_e;

  phase_e      phase_q, phase_d, phase_c;
  logic [31:0] acc_q, acc_d, acc_c;
  logic [1:0]  bif_q, bif_d, bif_c;
  logic [31:0] skip_q, skip_d, skip_c;
  logic [31:0] drem_q, drem_d, drem_c;
  logic [1:0]  ch_q, ch_d, ch_c;
  logic [4:0]  bits_q, bits_d, bits_c;
  logic [31:0] rate_q, rate_d, rate_c;
  logic [2:0]  fbytes_q, fbytes_d, fbytes_c;
  logic [1:0]  fidx_q, fidx_d, fidx_c;

  logic        accept;
  logic        restart;
  logic [31:0] acc_fld, acc_frm;
  logic        fld4_done, fld2_done;
  logic [1:0]  bif_nxt4, bif_nxt2;
  logic        res_valid;
  wpsp_pkg::result_t res;

  assign in_i.ready = !queue_full_i;
  assign accept     = in_i.valid & in_i.ready;
  assign restart    = in_i.file_start;

  // file_start clears everything before this word is parsed
  always_comb begin
    phase_c  = restart ? PH_RIFF : phase_q;
    acc_c    = restart ? '0 : acc_q;
    bif_c    = restart ? '0 : bif_q;
    skip_c   = restart ? '0 : skip_q;
    drem_c   = restart ? '0 : drem_q;
    ch_c     = restart ? '0 : ch_q;
    bits_c   = restart ? '0 : bits_q;
    rate_c   = restart ? '0 : rate_q;
    fbytes_c = restart ? '0 : fbytes_q;
    fidx_c   = restart ? '0 : fidx_q;
  end

  // little-endian field and frame assembly
  assign acc_fld   = ((bif_c == 2'd0) ? 32'd0 : acc_c)
                   | (32'(in_i.data_byte) << {bif_c, 3'b000});
  assign acc_frm   = ((fidx_c == 2'd0) ? 32'd0 : acc_c)
                   | (32'(in_i.data_byte) << {fidx_c, 3'b000});
  assign fld4_done = (bif_c == 2'd3);
  assign fld2_done = (bif_c != 2'd0);
  assign bif_nxt4  = fld4_done ? 2'd0 : bif_c + 2'd1;
  assign bif_nxt2  = fld2_done ? 2'd0 : bif_c + 2'd1;

  always_comb begin
    phase_d   = phase_c;
    acc_d     = acc_c;
    bif_d     = bif_c;
    skip_d    = skip_c;
    drem_d    = drem_c;
    ch_d      = ch_c;
    bits_d    = bits_c;
    rate_d    = rate_c;
    fbytes_d  = fbytes_c;
    fidx_d    = fidx_c;
    res_valid = 1'b0;
    res       = '0;

    unique case (phase_c) inside
      PH_RIFF: begin
        acc_d = acc_fld;
        bif_d = bif_nxt4;
        if (fld4_done) begin
          if (acc_fld != wpsp_pkg::TAG_RIFF) begin
            res_valid      = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_RIFF;
            phase_d        = PH_STREAM;
            drem_d         = '0;
          end else begin
            phase_d = PH_RIFF_SIZE;
          end
        end
      end
      PH_RIFF_SIZE: begin
        acc_d = acc_fld;
        bif_d = bif_nxt4;
        if (fld4_done) phase_d = PH_WAVE;
      end
      PH_WAVE: begin
        acc_d = acc_fld;
        bif_d = bif_nxt4;
        if (fld4_done) begin
          if (acc_fld != wpsp_pkg::TAG_WAVE) begin
            res_valid      = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_WAVE;
            phase_d        = PH_STREAM;
            drem_d         = '0;
          end else begin
            phase_d = PH_SCAN_FMT;
          end
        end
      end
      PH_SCAN_FMT: begin
        acc_d = acc_fld;
        bif_d = bif_nxt4;
        if (fld4_done && acc_fld == wpsp_pkg::TAG_FMT) phase_d = PH_FMT_SIZE;
      end
      PH_FMT_SIZE: begin
        acc_d = acc_fld;
        bif_d = bif_nxt4;
        if (fld4_done) begin
          if (acc_fld != wpsp_pkg::FMT_SIZE_BASE && acc_fld != wpsp_pkg::FMT_SIZE_EXT &&
              acc_fld != wpsp_pkg::FMT_SIZE_EXTENSIBLE) begin
            res_valid      = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_FMT_SIZE;
            phase_d        = PH_STREAM;
            drem_d         = '0;
          end else begin
            // extra fmt bytes parked in the data counter
            drem_d  = acc_fld - wpsp_pkg::FMT_SIZE_BASE;
            phase_d = PH_FORMAT;
          end
        end
      end
      PH_FORMAT: begin
        acc_d = acc_fld;
        bif_d = bif_nxt2;
        if (fld2_done) begin
          if (acc_fld != wpsp_pkg::FORMAT_PCM) begin
            res_valid      = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_NOT_PCM;
            phase_d        = PH_STREAM;
            drem_d         = '0;
          end else begin
            phase_d = PH_CHANNELS;
          end
        end
      end
      PH_CHANNELS: begin
        acc_d = acc_fld;
        bif_d = bif_nxt2;
        if (fld2_done) begin
          if (acc_fld < 32'd1 || acc_fld > 32'd2) begin
            res_valid      = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_CHANNELS;
            phase_d        = PH_STREAM;
            drem_d         = '0;
          end else begin
            ch_d    = acc_fld[1:0];
            phase_d = PH_RATE;
          end
        end
      end
      PH_RATE: begin
        acc_d = acc_fld;
        bif_d = bif_nxt4;
        if (fld4_done) begin
          if (acc_fld == 32'd0) begin
            res_valid      = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_RATE;
            phase_d        = PH_STREAM;
            drem_d         = '0;
          end else begin
            rate_d  = acc_fld;
            skip_d  = wpsp_pkg::SKIP_ALIGN_BYTES;
            phase_d = PH_SKIP6;
          end
        end
      end
      PH_SKIP6: begin
        skip_d = skip_c - 32'd1;
        if (skip_c == 32'd1) phase_d = PH_BITS;
      end
      PH_BITS: begin
        acc_d = acc_fld;
        bif_d = bif_nxt2;
        if (fld2_done) begin
          if (acc_fld != wpsp_pkg::BITS_8 && acc_fld != wpsp_pkg::BITS_16) begin
            res_valid      = 1'b1;
            res.kind       = wpsp_pkg::KIND_ERROR;
            res.error_code = wpsp_pkg::ERR_BITS;
            phase_d        = PH_STREAM;
            drem_d         = '0;
          end else begin
            bits_d   = acc_fld[4:0];
            fbytes_d = (acc_fld == wpsp_pkg::BITS_16) ? {ch_c, 1'b0} : {1'b0, ch_c};
            skip_d   = drem_c;
            drem_d   = '0;
            phase_d  = (drem_c != 32'd0) ? PH_EXTRA : PH_CHUNK_ID;
          end
        end
      end
      PH_EXTRA, PH_SKIP_BODY: begin
        skip_d = skip_c - 32'd1;
        if (skip_c == 32'd1) phase_d = PH_CHUNK_ID;
      end
      PH_CHUNK_ID: begin
        acc_d = acc_fld;
        bif_d = bif_nxt4;
        if (fld4_done) begin
          phase_d = (acc_fld == wpsp_pkg::TAG_DATA) ? PH_DATA_SIZE : PH_CHUNK_SIZE;
        end
      end
      PH_CHUNK_SIZE: begin
        acc_d = acc_fld;
        bif_d = bif_nxt4;
        if (fld4_done) begin
          skip_d  = acc_fld;
          phase_d = (acc_fld != 32'd0) ? PH_SKIP_BODY : PH_CHUNK_ID;
        end
      end
      PH_DATA_SIZE: begin
        acc_d = acc_fld;
        bif_d = bif_nxt4;
        if (fld4_done) begin
          drem_d            = acc_fld;
          fidx_d            = '0;
          acc_d             = '0;
          phase_d           = PH_STREAM;
          res_valid         = 1'b1;
          res.kind          = wpsp_pkg::KIND_FORMAT;
          res.channel_count = ch_c;
          res.sample_rate   = rate_c;
          res.sample_bits   = bits_c;
        end
      end
      PH_STREAM: begin
        // idle once the data count runs out
        if (drem_c != 32'd0 && fbytes_c != 3'd0) begin
          drem_d = drem_c - 32'd1;
          acc_d  = acc_frm;
          if ({1'b0, fidx_c} + 3'd1 < fbytes_c) begin
            fidx_d = fidx_c + 2'd1;
          end else begin
            fidx_d    = '0;
            res_valid = 1'b1;
            res.kind  = wpsp_pkg::KIND_FRAME;
            if (bits_c == wpsp_pkg::BITS_8[4:0]) begin
              res.left_sample  = {8'h00, acc_frm[7:0]};
              res.right_sample = (ch_c == 2'd2) ? {8'h00, acc_frm[15:8]} : 16'sd0;
            end else begin
              res.left_sample  = acc_frm[15:0];
              res.right_sample = (ch_c == 2'd2) ? acc_frm[31:16] : 16'sd0;
            end
          end
        end
      end
      default: begin
        phase_d = PH_RIFF;
      end
    endcase
  end

  assign push_o.valid = accept & res_valid;
  assign push_o.data  = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_RIFF;
      acc_q    <= '0;
      bif_q    <= '0;
      skip_q   <= '0;
      drem_q   <= '0;
      ch_q     <= '0;
      bits_q   <= '0;
      rate_q   <= '0;
      fbytes_q <= '0;
      fidx_q   <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      bif_q    <= bif_d;
      skip_q   <= skip_d;
      drem_q   <= drem_d;
      ch_q     <= ch_d;
      bits_q   <= bits_d;
      rate_q   <= rate_d;
      fbytes_q <= fbytes_d;
      fidx_q   <= fidx_d;
    end
  end

endmodule

/* design/wpsp_queue.sv */
`include "wav_pcm_stream_parser_core_defines.svh"

module wpsp_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wpsp_pkg::res_push_t push_i,
  output logic                full_o,
  wpsp_out_if.source          out_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  wpsp_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;
  wpsp_pkg::result_t head;

  assign push   = push_i.valid;
  assign pop    = out_o.valid & out_o.ready;
  assign full_o = (count_q == CntW'(Depth));
  assign head   = mem_q[rd_ptr_q];

  assign out_o.valid         = (count_q != '0);
  assign out_o.result_kind   = head.kind;
  assign out_o.left_sample   = head.left_sample;
  assign out_o.right_sample  = head.right_sample;
  assign out_o.channel_count = head.channel_count;
  assign out_o.sample_rate   = head.sample_rate;
  assign out_o.sample_bits   = head.sample_bits;
  assign out_o.error_code    = head.error_code;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `WPSP_ASSERT_IMP(a_no_overflow, push, !full_o, "result pushed into a full queue")
  `WPSP_ASSERT_IMP(a_count_max, 1'b1, count_q <= CntW'(Depth), "queue count out of range")
  `WPSP_ASSERT_NXT(a_count_up, push && !pop, count_q == $past(count_q) + CntW'(1), "count missed push")
  `WPSP_ASSERT_NXT(a_count_dn, pop && !push, count_q == $past(count_q) - CntW'(1), "count missed pop")

endmodule
